/* hdl/pixel_background_subtractor_assert.svh */
// assertion macros shared by the pixel background subtractor
`ifndef PIXEL_BACKGROUND_SUBTRACTOR_ASSERT_SVH
`define PIXEL_BACKGROUND_SUBTRACTOR_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define PBS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, checked on every rising edge outside reset
`define PBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hdl/pbs_pkg.sv */
`default_nettype none

package pbs_pkg;

  // one incoming pixel transaction
  typedef struct packed {
    logic [15:0] pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        load_background;
  } pixel_in_t;

  // one result transaction
  typedef struct packed {
    logic [7:0] highlight_level;
    logic       is_foreground;
  } pixel_out_t;

  // threshold register
  localparam int unsigned THRESH_W = 9;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 9'd50;

  // squared distance: three channels of 255^2 fit in 18 bits
  localparam int unsigned DIST_SQ_W = 18;
  localparam logic [DIST_SQ_W-1:0] THRESH_SQ_RESET = DIST_SQ_W'(50 * 50);

  // running average: floor((19*bg + p) / 20), division by reciprocal
  localparam int unsigned BLEND_SUM_W = 13;
  localparam logic [BLEND_SUM_W-1:0] ADAPT_KEEP = 13'd19;
  localparam int unsigned RECIP_W = 24;
  localparam logic [RECIP_W-1:0] RECIP_20 = 24'd3277;

  // highlight saturation
  localparam logic [7:0] LEVEL_MAX = 8'd255;

endpackage

`default_nettype wire

/* hdl/pixel_background_subtractor.sv */
// Pixel background subtractor: running average background model per pixel.
// Input channel pixel/pixel_valid/pixel_stall carries one RGB pixel with its
// frame index and a load flag; output channel result/result_valid/
// result_stall returns one highlight level and foreground flag per pixel.
// cfg_write_en with cfg_write_data sets the match threshold (reset 50).
// Each pixel passes the stage registers p1 to p5, then the result register.
// Throughput: one pixel per clock while no result is stalled and indices
// differ from the three pixels ahead in the read-modify-write window
// (stages 1 to 3); a pixel whose index matches one of them waits until
// that write has landed. The background store takes one write and one
// read per cycle, with registered read data.
// Reset clears all valid bits and returns the threshold to 50; background
// entries stay undefined until a pixel with load_background writes them.
// When the receiver stalls a waiting result, the whole pipeline holds and
// pixel_stall rises in the same cycle; nothing is dropped or repeated.
`default_nettype none

`include "pixel_background_subtractor_assert.svh"

module pixel_background_subtractor #(
  parameter int MAX_PIXELS = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     pixel_valid,
  output logic                          pixel_stall,
  input  wire pbs_pkg::pixel_in_t       pixel,
  output logic                          result_valid,
  input  wire logic                     result_stall,
  output pbs_pkg::pixel_out_t           result,
  input  wire logic                     cfg_write_en,
  input  wire logic [pbs_pkg::THRESH_W-1:0] cfg_write_data
);

  localparam int DEPTH  = (MAX_PIXELS < 65536) ? MAX_PIXELS : 65536;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SQ_W   = pbs_pkg::DIST_SQ_W;

  typedef struct packed {
    logic [15:0] rem;
    logic [15:0] root;
  } sqrt_state_t;

  // one digit of the bitwise integer square root, bit weight 4^k
  function automatic sqrt_state_t sqrt_step(sqrt_state_t s, logic [2:0] k);
    logic [15:0] bit_val;
    logic [16:0] trial;
    sqrt_state_t n;
    bit_val = 16'd1 << {k, 1'b0};
    trial   = {1'b0, s.root} + {1'b0, bit_val};
    if ({1'b0, s.rem} >= trial) begin
      n.rem  = s.rem - trial[15:0];
      n.root = (s.root >> 1) + bit_val;
    end else begin
      n.rem  = s.rem;
      n.root = s.root >> 1;
    end
    return n;
  endfunction

  // pipeline advance: hold everything while a result waits on a stall
  logic adv;
  logic hazard;
  logic pixel_acc;
  logic pixel_in_range;

  assign adv       = !(result_valid && result_stall);
  assign pixel_in_range = ({16'd0, pixel.pixel_index} < 32'(MAX_PIXELS));

  // threshold, kept squared
  logic [SQ_W-1:0] thresh_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh_sq <= pbs_pkg::THRESH_SQ_RESET;
    end else if (cfg_write_en) begin
      thresh_sq <= SQ_W'(cfg_write_data) * SQ_W'(cfg_write_data);
    end
  end

  // stage 1 registers
  logic        p1_valid;
  logic        p1_in_range;
  logic        p1_load;
  logic [15:0] p1_index;
  logic [23:0] p1_pix;
  logic [23:0] p1_rd;

  // stage 2 registers
  logic        p2_valid;
  logic        p2_in_range;
  logic        p2_load;
  logic [15:0] p2_index;
  logic [23:0] p2_pix;
  logic [7:0]  p2_diff [3];
  logic [pbs_pkg::BLEND_SUM_W-1:0] p2_sum [3];

  // stage 3 registers
  logic        p3_valid;
  logic        p3_in_range;
  logic        p3_load;
  logic [15:0] p3_index;
  logic [23:0] p3_pix;
  logic [15:0] p3_sq [3];
  logic [23:0] p3_blend;

  // stage 4 and 5 registers
  logic        p4_valid;
  logic        p4_fg;
  logic        p4_sat;
  logic [15:0] p4_v;
  logic        p5_valid;
  logic        p5_fg;
  logic        p5_sat;
  sqrt_state_t p5_sqrt;

  // read-after-write hazard against pixels not yet written back
  assign hazard = pixel_in_range && (
      (p1_valid && p1_in_range && (p1_index == pixel.pixel_index)) ||
      (p2_valid && p2_in_range && (p2_index == pixel.pixel_index)) ||
      (p3_valid && p3_in_range && (p3_index == pixel.pixel_index)));

  assign pixel_stall = !adv || hazard;
  assign pixel_acc   = pixel_valid && !pixel_stall;

  // background store
  logic [23:0]       bg_mem [DEPTH];
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [23:0]       mem_wdata;

  assign rd_addr = pixel.pixel_index[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_rd <= bg_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bg_mem[mem_waddr] <= mem_wdata;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid     <= 1'b0;
      p2_valid     <= 1'b0;
      p3_valid     <= 1'b0;
      p4_valid     <= 1'b0;
      p5_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      p1_valid     <= pixel_acc;
      p2_valid     <= p1_valid;
      p3_valid     <= p2_valid;
      p4_valid     <= p3_valid;
      p5_valid     <= p4_valid;
      result_valid <= p5_valid;
    end
  end

  // stage 0: capture the incoming transaction
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_in_range <= pixel_in_range;
      p1_load     <= pixel.load_background;
      p1_index    <= pixel.pixel_index;
      p1_pix      <= {pixel.red, pixel.green, pixel.blue};
    end
  end

  // stage 1: pick background, channel distances and blend sums
  logic [23:0] s1_bg;
  logic [7:0]  s1_diff [3];
  logic [pbs_pkg::BLEND_SUM_W-1:0] s1_sum [3];

  always_comb begin
    if (!p1_in_range) begin
      s1_bg = 24'd0;
    end else if (p1_load) begin
      s1_bg = p1_pix;
    end else begin
      s1_bg = p1_rd;
    end
    for (int c = 0; c < 3; c++) begin
      if (p1_pix[c*8 +: 8] >= s1_bg[c*8 +: 8]) begin
        s1_diff[c] = p1_pix[c*8 +: 8] - s1_bg[c*8 +: 8];
      end else begin
        s1_diff[c] = s1_bg[c*8 +: 8] - p1_pix[c*8 +: 8];
      end
      s1_sum[c] = pbs_pkg::BLEND_SUM_W'(s1_bg[c*8 +: 8]) * pbs_pkg::ADAPT_KEEP
                + pbs_pkg::BLEND_SUM_W'(p1_pix[c*8 +: 8]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_in_range <= p1_in_range;
      p2_load     <= p1_load;
      p2_index    <= p1_index;
      p2_pix      <= p1_pix;
      p2_diff     <= s1_diff;
      p2_sum      <= s1_sum;
    end
  end

  // stage 2: squares and divide blend sums by 20
  logic [15:0] s2_sq [3];
  logic [23:0] s2_blend;
  logic [pbs_pkg::RECIP_W-1:0] s2_prod [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s2_sq[c]   = {8'd0, p2_diff[c]} * {8'd0, p2_diff[c]};
      s2_prod[c] = pbs_pkg::RECIP_W'(p2_sum[c]) * pbs_pkg::RECIP_20;
      s2_blend[c*8 +: 8] = s2_prod[c][23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_in_range <= p2_in_range;
      p3_load     <= p2_load;
      p3_index    <= p2_index;
      p3_pix      <= p2_pix;
      p3_sq       <= s2_sq;
      p3_blend    <= s2_blend;
    end
  end

  // stage 3: squared distance, threshold test, background write-back
  logic [SQ_W-1:0] s3_d2;
  logic            s3_match;

  assign s3_d2    = SQ_W'(p3_sq[0]) + SQ_W'(p3_sq[1]) + SQ_W'(p3_sq[2]);
  assign s3_match = (s3_d2 < thresh_sq);

  assign mem_we    = adv && p3_valid && p3_in_range && (s3_match || p3_load);
  assign mem_waddr = p3_index[ADDR_W-1:0];
  assign mem_wdata = s3_match ? p3_blend : p3_pix;

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_fg  <= !s3_match;
      p4_sat <= (s3_d2[SQ_W-1:14] != '0);
      p4_v   <= {s3_d2[13:0], 2'b00};
    end
  end

  // stage 4: upper four root digits
  sqrt_state_t s4_sqrt;

  always_comb begin
    s4_sqrt.rem  = p4_v;
    s4_sqrt.root = 16'd0;
    for (int i = 0; i < 4; i++) begin
      s4_sqrt = sqrt_step(s4_sqrt, 3'(7 - i));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p5_fg   <= p4_fg;
      p5_sat  <= p4_sat;
      p5_sqrt <= s4_sqrt;
    end
  end

  // stage 5: lower four root digits and result formatting
  sqrt_state_t s5_sqrt;
  pbs_pkg::pixel_out_t s5_out;

  always_comb begin
    s5_sqrt = p5_sqrt;
    for (int i = 0; i < 4; i++) begin
      s5_sqrt = sqrt_step(s5_sqrt, 3'(3 - i));
    end
    s5_out.is_foreground = p5_fg;
    if (!p5_fg) begin
      s5_out.highlight_level = 8'd0;
    end else if (p5_sat) begin
      s5_out.highlight_level = pbs_pkg::LEVEL_MAX;
    end else begin
      s5_out.highlight_level = s5_sqrt.root[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= s5_out;
    end
  end

  // checks
  `PBS_ASSERT_NOW(a_background_is_black,
                  result_valid && !result.is_foreground, result.highlight_level == 8'd0)
  `PBS_ASSERT_NOW(a_no_read_write_collision,
                  mem_we && pixel_acc && pixel_in_range, mem_waddr != rd_addr)
  `PBS_ASSERT_NEXT(a_stalled_result_blocks_input,
                   result_valid && result_stall, result_valid)

endmodule

`default_nettype wire

/* sim/tb_pixel_background_subtractor.sv */
`default_nettype none

module tb_pixel_background_subtractor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_COUNT = 7;
  localparam int unsigned PHASE_ITEMS = 80;
  localparam int unsigned CALM_ITEMS = 90;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned HOT_COUNT = 12;

  // per-pixel background model and queue of results still owed by the block
  class background_tracker;
    logic [23:0] bg_store [int];
    logic [pbs_pkg::THRESH_W-1:0] threshold;
    pbs_pkg::pixel_out_t pending_outputs [$];
    int unsigned errors;
    int unsigned results_seen;

    function new();
      threshold = pbs_pkg::THRESH_RESET;
      errors = 0;
      results_seen = 0;
    endfunction

    function int root_floor(int v);
      int root;
      int trial;
      root = 0;
      for (int b = 10; b >= 0; b--) begin
        trial = root | (1 << b);
        if (trial * trial <= v) root = trial;
      end
      return root;
    endfunction

    function logic [7:0] blend(logic [7:0] bg, logic [7:0] p);
      return 8'((int'(bg) * 19 + int'(p)) / 20);
    endfunction

    function bit has_background(logic [15:0] idx);
      return bg_store.exists(int'(idx));
    endfunction

    function logic [23:0] background_of(logic [15:0] idx);
      return bg_store.exists(int'(idx)) ? bg_store[int'(idx)] : 24'd0;
    endfunction

    // classify an accepted pixel, adapt the stored background, queue the result
    function void accept_pixel(pbs_pkg::pixel_in_t px);
      logic [23:0] bg;
      int p_ch [3];
      int b_ch [3];
      int dist_sq;
      int level;
      pbs_pkg::pixel_out_t out;
      if (px.load_background) bg_store[int'(px.pixel_index)] = {px.red, px.green, px.blue};
      bg = background_of(px.pixel_index);
      p_ch = '{int'(px.red), int'(px.green), int'(px.blue)};
      b_ch = '{int'(bg[23:16]), int'(bg[15:8]), int'(bg[7:0])};
      dist_sq = 0;
      for (int c = 0; c < 3; c++) dist_sq += (p_ch[c] - b_ch[c]) * (p_ch[c] - b_ch[c]);
      if (dist_sq < int'(threshold) * int'(threshold)) begin
        bg_store[int'(px.pixel_index)] = {blend(bg[23:16], px.red), blend(bg[15:8], px.green),
                                          blend(bg[7:0], px.blue)};
        out.highlight_level = '0;
        out.is_foreground = 1'b0;
      end else begin
        level = root_floor(4 * dist_sq);
        out.highlight_level = (level > int'(pbs_pkg::LEVEL_MAX)) ? pbs_pkg::LEVEL_MAX
                                                                 : 8'(level);
        out.is_foreground = 1'b1;
      end
      pending_outputs.push_back(out);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    // compare one accepted result with the oldest owed one
    task match_output(pbs_pkg::pixel_out_t got);
      pbs_pkg::pixel_out_t want;
      results_seen++;
      if (pending_outputs.size() == 0) begin
        report_mismatch("result with nothing outstanding");
        return;
      end
      want = pending_outputs.pop_front();
      if (got.highlight_level !== want.highlight_level)
        report_mismatch($sformatf("highlight_level got %0d want %0d",
                                  got.highlight_level, want.highlight_level));
      if (got.is_foreground !== want.is_foreground)
        report_mismatch($sformatf("is_foreground got %0b want %0b",
                                  got.is_foreground, want.is_foreground));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pixel_valid = 1'b0;
  logic pixel_stall;
  pbs_pkg::pixel_in_t pixel = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  pbs_pkg::pixel_out_t result;
  logic cfg_write_en = 1'b0;
  logic [pbs_pkg::THRESH_W-1:0] cfg_write_data = '0;

  bit calm = 1'b0;
  int unsigned cycle_count = 0;
  background_tracker tracker;
  logic [15:0] hot_index [HOT_COUNT] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA,
                                         16'h8000, 16'h7FFF, 16'h00FF, 16'hFF00, 16'h1234,
                                         16'h0F0F, 16'hF0F0};

  pixel_background_subtractor dut (
    .clk            (clk),
    .rst            (rst),
    .pixel_valid    (pixel_valid),
    .pixel_stall    (pixel_stall),
    .pixel          (pixel),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) tracker.match_output(result);
  end

  // receiver stall bursts
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (calm) begin
        burst = 0;
        result_stall <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        result_stall <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 4) - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  function automatic pbs_pkg::pixel_in_t make_pixel(logic [15:0] idx, logic [7:0] r,
                                                    logic [7:0] g, logic [7:0] b,
                                                    logic load);
    pbs_pkg::pixel_in_t px;
    px.pixel_index = idx;
    px.red = r;
    px.green = g;
    px.blue = b;
    px.load_background = load;
    return px;
  endfunction

  function automatic logic [7:0] nudge(logic [7:0] base, int spread);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // mostly revisits a few indices; never reads an entry that was not loaded
  function automatic pbs_pkg::pixel_in_t random_pixel();
    pbs_pkg::pixel_in_t px;
    logic [23:0] bg;
    int pick;
    int spread;
    pick = $urandom_range(0, 99);
    if (pick < 35) px.pixel_index = hot_index[$urandom_range(0, 2)];
    else if (pick < 85) px.pixel_index = hot_index[$urandom_range(0, HOT_COUNT - 1)];
    else px.pixel_index = 16'($urandom);
    px.load_background = !tracker.has_background(px.pixel_index) ||
                         ($urandom_range(0, 9) == 0);
    bg = tracker.background_of(px.pixel_index);
    if (!px.load_background && $urandom_range(0, 9) < 6) begin
      spread = $urandom_range(0, (tracker.threshold > 255) ? 255 : int'(tracker.threshold));
      px.red = nudge(bg[23:16], spread);
      px.green = nudge(bg[15:8], spread);
      px.blue = nudge(bg[7:0], spread);
    end else begin
      px.red = 8'($urandom);
      px.green = 8'($urandom);
      px.blue = 8'($urandom);
    end
    return px;
  endfunction

  task automatic idle_input(int n);
    repeat (n) begin
      @(negedge clk);
      pixel_valid <= 1'b0;
    end
  endtask

  // one pixel transaction, with an occasional gap in front
  task automatic send_pixel(pbs_pkg::pixel_in_t px);
    if (!calm && $urandom_range(0, 3) == 0) idle_input($urandom_range(1, 4));
    @(negedge clk);
    pixel_valid <= 1'b1;
    pixel <= px;
    do @(posedge clk); while (pixel_stall);
    tracker.accept_pixel(px);
  endtask

  // hold the sender until every owed result is back and the pipeline is empty
  task automatic drain();
    @(negedge clk);
    pixel_valid <= 1'b0;
    while (tracker.pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [pbs_pkg::THRESH_W-1:0] value);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    tracker.threshold = value;
  endtask

  initial begin
    logic [pbs_pkg::THRESH_W-1:0] phase_threshold [PHASE_COUNT];
    tracker = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, exact threshold edge, same-index runs
    send_pixel(make_pixel(16'h0000, 8'd0, 8'd0, 8'd0, 1'b1));
    send_pixel(make_pixel(16'h0000, 8'd255, 8'd255, 8'd255, 1'b0));
    send_pixel(make_pixel(16'h0000, 8'd10, 8'd10, 8'd10, 1'b0));
    send_pixel(make_pixel(16'hFFFF, 8'd255, 8'd255, 8'd255, 1'b1));
    send_pixel(make_pixel(16'hFFFF, 8'd0, 8'd0, 8'd0, 1'b0));
    send_pixel(make_pixel(16'hFFFF, 8'd255, 8'd0, 8'd255, 1'b0));
    send_pixel(make_pixel(16'h0001, 8'd100, 8'd100, 8'd100, 1'b1));
    send_pixel(make_pixel(16'h0001, 8'd150, 8'd100, 8'd100, 1'b0));
    send_pixel(make_pixel(16'h0001, 8'd149, 8'd100, 8'd100, 1'b0));
    send_pixel(make_pixel(16'h0001, 8'd100, 8'd149, 8'd100, 1'b0));
    send_pixel(make_pixel(16'h0001, 8'd120, 8'd120, 8'd120, 1'b0));
    send_pixel(make_pixel(16'h0001, 8'd130, 8'd110, 8'd90, 1'b0));
    send_pixel(make_pixel(16'h5555, 8'h12, 8'h34, 8'h56, 1'b1));
    send_pixel(make_pixel(16'h5555, 8'hAA, 8'h55, 8'hAA, 1'b0));
    send_pixel(make_pixel(16'hAAAA, 8'hAA, 8'h55, 8'hAA, 1'b1));
    send_pixel(make_pixel(16'hAAAA, 8'h55, 8'hAA, 8'h55, 1'b0));
    send_pixel(make_pixel(16'hAAAA, 8'h55, 8'hAA, 8'h55, 1'b1));
    send_pixel(make_pixel(16'h0000, 8'd255, 8'd0, 8'd0, 1'b0));
    send_pixel(make_pixel(16'h0000, 8'd0, 8'd0, 8'd35, 1'b0));
    send_pixel(make_pixel(16'hFFFF, 8'd250, 8'd250, 8'd250, 1'b0));
    drain();

    // random phases across threshold settings, extremes included
    phase_threshold[0] = '0;
    phase_threshold[1] = 9'd442;
    phase_threshold[2] = 9'd1;
    phase_threshold[3] = 9'd511;
    phase_threshold[4] = 9'($urandom_range(2, 441));
    phase_threshold[5] = 9'd20;
    phase_threshold[6] = 9'd200;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      write_threshold(phase_threshold[ph]);
      repeat (PHASE_ITEMS) send_pixel(random_pixel());
      drain();
    end

    // back to the reset threshold, no idling on either side
    write_threshold(pbs_pkg::THRESH_RESET);
    calm = 1'b1;
    repeat (CALM_ITEMS) send_pixel(random_pixel());
    drain();

    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+hdl
hdl/pbs_pkg.sv
hdl/pixel_background_subtractor.sv
sim/tb_pixel_background_subtractor.sv
